// ===== design/hd_pkg.sv =====
// Package: widths, codes, table entry format and state encoding of the Huffman tree decoder.
package hd_pkg;

    // Table geometry
    localparam int TABLE_DEPTH     = 2048;
    localparam int MAX_CODE_LENGTH = 10;
    localparam int ADDR_W          = $clog2(TABLE_DEPTH);
    localparam int NEXT_W          = ADDR_W + 1;
    localparam int WALK_LIMIT      = ((1 << (MAX_CODE_LENGTH + 1)) < TABLE_DEPTH) ?
                                     (1 << (MAX_CODE_LENGTH + 1)) : TABLE_DEPTH;

    // Payload widths
    localparam int SYM_W  = 8;
    localparam int CODE_W = 10;
    localparam int LEN_W  = 4;
    localparam int STAT_W = 2;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } hd_cmd_t;

    typedef enum logic [STAT_W-1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } hd_status_t;

    // One node of the code tree; all zero means empty
    typedef struct packed
    {
        logic             inner;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } hd_entry_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DECODE
    } hd_state_t;

endpackage

// ===== design/hd_item_if.sv =====
// Interfaces: input item channel and result channel of the Huffman tree decoder.
interface hd_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] symbol_in;
    logic [9:0] code_bits;
    logic [3:0] code_length;
    logic       data_bit;

    modport source (output valid, command, symbol_in, code_bits, code_length, data_bit,
                    input ready);
    modport sink   (input valid, command, symbol_in, code_bits, code_length, data_bit,
                    output ready);
endinterface

interface hd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_out;
    logic [1:0] status;

    modport source (output valid, symbol_out, status, input ready);
    modport sink   (input valid, symbol_out, status, output ready);
endinterface

// ===== design/huffman_tree_decoder.sv =====
// Top level: Huffman decoder walking a heap-ordered code tree held in one synchronous RAM.
//
// The code tree lives in a 2048 x 10 single-port-write, registered-read RAM; node n has
// children 2n and 2n+1, the root is node 1. After reset the block runs a clearing pass
// (item.ready low) that empties every node. For a decode item (one stream bit) the accept
// cycle issues the RAM read of the child node and the next cycle evaluates the entry
// and, on a leaf, an empty node or a walk past the tree depth, pushes one result into
// the output register. A load item makes one RAM write per code bit. Loads with a bad
// length, or whose leaf would fall outside the table, are dropped in their accept cycle.
// The output register lets the next item be accepted while a result waits; a decode
// stalls only when it must push a result and the register is still full.
module huffman_tree_decoder
(
    input  logic           clk,
    input  logic           rst_n,
    hd_item_if.sink        item,
    hd_result_if.source    result
);
    import hd_pkg::*;

    localparam logic [NEXT_W-1:0] LIMIT_N = NEXT_W'(WALK_LIMIT);
    localparam logic [ADDR_W-1:0] ROOT    = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(TABLE_DEPTH - 1);

    // Node memory
    hd_entry_t          mem [TABLE_DEPTH];
    hd_entry_t          rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    hd_entry_t          mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    // Control and datapath registers
    hd_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  cur_node_reg;
    logic [ADDR_W-1:0]  dec_node_reg;
    logic               too_long_reg;
    logic [ADDR_W-1:0]  ld_node_reg;
    logic [CODE_W-1:0]  ld_code_reg;
    logic [LEN_W-1:0]   ld_cnt_reg;
    logic [SYM_W-1:0]   ld_sym_reg;
    logic               out_valid_reg;
    logic [SYM_W-1:0]   out_sym_reg;
    hd_status_t         out_status_reg;

    // Decode of the incoming item
    logic               accept;
    logic               is_load;
    logic [NEXT_W-1:0]  dec_next;
    logic               dec_too_long;
    logic [CODE_W-1:0]  len_mask;
    logic [NEXT_W-1:0]  ld_deepest;
    logic               ld_ok;
    logic [CODE_W-1:0]  ld_aligned;
    logic [ADDR_W-1:0]  ld_step_node;

    // Decode evaluation
    logic               dec_need_out;
    logic               out_free;
    logic               dec_done;
    logic               push;
    logic [SYM_W-1:0]   push_sym;
    hd_status_t         push_status;

    assign accept  = item.valid & item.ready;
    assign is_load = (hd_cmd_t'(item.command) == CMD_LOAD);

    // Child index of the current node for this stream bit
    assign dec_next     = {1'b0, cur_node_reg} << 1 | NEXT_W'(item.data_bit);
    assign dec_too_long = (dec_next >= LIMIT_N);

    // Load checks: length range and leaf inside the walk limit
    assign len_mask   = ~({CODE_W{1'b1}} << item.code_length);
    assign ld_deepest = (NEXT_W'(1) << item.code_length)
                        | NEXT_W'(item.code_bits & len_mask);
    assign ld_ok      = (item.code_length != '0)
                        && (item.code_length <= LEN_W'(MAX_CODE_LENGTH))
                        && (ld_deepest < LIMIT_N);
    assign ld_aligned = item.code_bits << (LEN_W'(CODE_W) - item.code_length);

    // Next node on the load path
    assign ld_step_node = {ld_node_reg[ADDR_W-2:0], ld_code_reg[CODE_W-1]};

    // Result of the pending decode step
    assign dec_need_out = too_long_reg || !rd_data_reg.inner;
    assign out_free     = !out_valid_reg || result.ready;
    assign dec_done     = !dec_need_out || out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_load)
                        state_next = ST_DECODE;
                    else if (ld_ok)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (ld_cnt_reg == LEN_W'(1))
                    state_next = ST_IDLE;
            end
            ST_DECODE:
            begin
                if (dec_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Outputs of the state machine: RAM ports, ready and result push
    always_comb
    begin
        item.ready  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = clr_addr_reg;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = dec_next[ADDR_W-1:0];
        push        = 1'b0;
        push_sym    = '0;
        push_status = STATUS_OK;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                item.ready = 1'b1;
                mem_re     = accept && !is_load && !dec_too_long;
            end
            ST_LOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = ld_step_node;
                if (ld_cnt_reg == LEN_W'(1))
                begin
                    mem_wdata.leaf = 1'b1;
                    mem_wdata.sym  = ld_sym_reg;
                end
                else
                begin
                    mem_wdata.inner = 1'b1;
                end
            end
            ST_DECODE:
            begin
                push = dec_need_out && out_free;
                priority if (too_long_reg)
                    push_status = STATUS_TOO_LONG;
                else if (rd_data_reg.leaf)
                    push_sym = rd_data_reg.sym;
                else
                    push_status = STATUS_INVALID;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cur_node_reg  <= ROOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (state_reg == ST_DECODE && dec_done)
                cur_node_reg <= dec_need_out ? ROOT : dec_node_reg;
            if (push)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_node_reg <= dec_next[ADDR_W-1:0];
            too_long_reg <= dec_too_long;
            ld_node_reg  <= ROOT;
            ld_code_reg  <= ld_aligned;
            ld_cnt_reg   <= item.code_length;
            ld_sym_reg   <= item.symbol_in;
        end
        else if (state_reg == ST_LOAD)
        begin
            ld_node_reg <= ld_step_node;
            ld_code_reg <= ld_code_reg << 1;
            ld_cnt_reg  <= ld_cnt_reg - LEN_W'(1);
        end
        if (push)
        begin
            out_sym_reg    <= push_sym;
            out_status_reg <= push_status;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.symbol_out = out_sym_reg;
    assign result.status     = out_status_reg;

endmodule

// ===== design/hd_checker.sv =====
// Checker: port-level assertions on the Huffman tree decoder, bound to the top level.
module hd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       item_command,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] symbol_out,
    input logic [1:0] status
);
    import hd_pkg::*;

    // A pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
                                          && $stable(symbol_out))
    else $error("result changed while stalled");

    // Status is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status == STATUS_OK || status == STATUS_INVALID
                         || status == STATUS_TOO_LONG)
    else $error("undefined status code");

    // Error results carry symbol zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STATUS_OK |-> symbol_out == '0)
    else $error("error result with nonzero symbol");

    // A load transfer never raises a result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_command == CMD_LOAD && !result_valid
        |=> !result_valid)
    else $error("load produced a result");

endmodule

bind huffman_tree_decoder hd_checker u_hd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_command (item.command),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .symbol_out   (result.symbol_out),
    .status       (result.status)
);

// ===== tb/testbench.sv =====
// Testbench for huffman_tree_decoder: random code trees loaded and decoded against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hd_pkg::*;

    // Scoreboard: mirrors the code tree and the walk position, queues predicted results
    class hd_scoreboard;
        typedef struct
        {
            logic [SYM_W-1:0] sym;
            hd_status_t       st;
        } decoded_t;

        hd_entry_t   tree [TABLE_DEPTH];
        int unsigned walk_node;
        decoded_t    decoded_q [$];
        int          errors;
        int          n_load;
        int          n_decode;
        int          n_status [3];

        function new();
            foreach (tree[i])
                tree[i] = '0;
            walk_node = 1;
            errors    = 0;
            n_load    = 0;
            n_decode  = 0;
            foreach (n_status[i])
                n_status[i] = 0;
        endfunction

        // Note an accepted item; returns 0 when the block drops it
        function bit note_item(hd_cmd_t cmd, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] bits,
                               logic [LEN_W-1:0] len, logic data_bit);
            int unsigned n;
            int unsigned next;
            hd_entry_t   e;
            decoded_t    d;
            if (cmd == CMD_LOAD)
            begin
                if (len == 0 || len > MAX_CODE_LENGTH)
                    return 0;
                n = 1;
                for (int k = 0; k < len; k++)
                    n = 2 * n + bits[len - 1 - k];
                if (n >= WALK_LIMIT)
                    return 0;
                // prefix nodes become internal, the last one turns into the leaf
                n = 1;
                for (int k = 0; k < len; k++)
                begin
                    n = 2 * n + bits[len - 1 - k];
                    tree[n] = '{inner: 1'b1, leaf: 1'b0, sym: '0};
                end
                tree[n] = '{inner: 1'b0, leaf: 1'b1, sym: sym};
                n_load++;
                return 1;
            end
            n_decode++;
            next = 2 * walk_node + data_bit;
            if (next >= WALK_LIMIT)
            begin
                walk_node = 1;
                d = '{sym: '0, st: STATUS_TOO_LONG};
                decoded_q.push_back(d);
                return 1;
            end
            e = tree[next];
            if (e.inner)
            begin
                walk_node = next;
                return 1;
            end
            walk_node = 1;
            if (e.leaf)
                d = '{sym: e.sym, st: STATUS_OK};
            else
                d = '{sym: '0, st: STATUS_INVALID};
            decoded_q.push_back(d);
            return 1;
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [SYM_W-1:0] sym, logic [STAT_W-1:0] st);
            decoded_t d;
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: symbol_out %0d status %0d", sym, st);
                errors++;
                return;
            end
            d = decoded_q.pop_front();
            if (d.st < 3)
                n_status[d.st]++;
            if (st !== d.st)
            begin
                $error("status: expected %0d, actual %0d", d.st, st);
                errors++;
            end
            if (sym !== d.sym)
            begin
                $error("symbol_out: expected %0d, actual %0d", d.sym, sym);
                errors++;
            end
        endfunction
    endclass

    typedef struct
    {
        logic [CODE_W-1:0] bits;
        int                len;
    } code_word_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   n_items;

    hd_item_if   item_ch ();
    hd_result_if result_ch ();

    hd_scoreboard sb = new();

    huffman_tree_decoder uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One item transfer; valid stays high when the next item follows without a gap
    task automatic send_item(input logic cmd, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len,
                             input logic data_bit);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.symbol_in   <= sym;
        item_ch.code_bits   <= bits;
        item_ch.code_length <= len;
        item_ch.data_bit    <= data_bit;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (sb.note_item(hd_cmd_t'(cmd), sym, bits, len, data_bit))
            n_items++;
    endtask

    // Load with random filler above the code word
    task automatic load_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input int len);
        logic [CODE_W-1:0] bits;
        bits = (CODE_W'($urandom_range(0, 1023)) << len) | code;
        send_item(CMD_LOAD, sym, bits, LEN_W'(len), 1'($urandom));
    endtask

    // Decode transfers for one code word, MSB first; unused fields carry junk
    task automatic decode_code(input logic [CODE_W-1:0] code, input int len);
        for (int k = len - 1; k >= 0; k--)
            send_item(CMD_DECODE, SYM_W'($urandom_range(0, 255)),
                      CODE_W'($urandom_range(0, 1023)), LEN_W'($urandom_range(0, 15)),
                      code[k]);
    endtask

    task automatic send_noise();
        send_item(1'($urandom), SYM_W'($urandom_range(0, 255)),
                  CODE_W'($urandom_range(0, 1023)), LEN_W'($urandom_range(0, 15)),
                  1'($urandom));
    endtask

    // Result sink: check every transfer, stall at random
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.symbol_out, result_ch.status);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 5) == 0)
                    stall = pick_gap() + 1;
            end
        end
    end

    // Stimulus
    initial
    begin
        code_word_t        codes [$];
        code_word_t        c;
        logic [SYM_W-1:0]  syms [$];
        int                idx;
        int                splits;

        n_items = 0;
        steady  = 1'b0;
        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.command       <= CMD_LOAD;
        item_ch.symbol_in     <= '0;
        item_ch.code_bits     <= '0;
        item_ch.code_length   <= '0;
        item_ch.data_bit      <= 1'b0;
        result_ch.ready       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: both first steps hit an empty node
        decode_code(10'b0, 1);
        decode_code(10'b1, 1);
        // Bad lengths are dropped
        send_item(CMD_LOAD, 8'd7, 10'h3FF, 4'd0, 1'b0);
        send_item(CMD_LOAD, 8'd7, 10'h3FF, 4'd11, 1'b1);
        send_item(CMD_LOAD, 8'd7, 10'h3FF, 4'd15, 1'b1);
        // Small tree with extreme symbols, filler bits above the code and a full-depth code
        send_item(CMD_LOAD, 8'd255, 10'h3FE, 4'd1, 1'b1);
        send_item(CMD_LOAD, 8'd0, 10'h3FE, 4'd2, 1'b0);
        send_item(CMD_LOAD, 8'hA5, 10'h3FF, 4'd10, 1'b0);
        decode_code(10'b0, 1);
        decode_code(10'b10, 2);
        decode_code(10'h3FF, 10);
        // Conflicting loads: a leaf over an internal node, then internal again
        send_item(CMD_LOAD, 8'h33, 10'b1, 4'd1, 1'b0);
        decode_code(10'b1, 1);
        send_item(CMD_LOAD, 8'h11, 10'b10, 4'd2, 1'b1);
        decode_code(10'b10, 2);

        // Random code trees: load a prefix-free set, then decode random symbols from it
        while (n_items < 1150)
        begin
            steady = ($urandom_range(0, 3) == 0);
            codes.delete();
            syms.delete();
            codes.push_back('{bits: 10'b0, len: 1});
            codes.push_back('{bits: 10'b1, len: 1});
            splits = $urandom_range(0, 20);
            repeat (splits)
            begin
                idx = $urandom_range(0, 1) ? codes.size() - 1
                                           : $urandom_range(0, codes.size() - 1);
                if (codes[idx].len < MAX_CODE_LENGTH)
                begin
                    c = codes[idx];
                    codes.delete(idx);
                    codes.push_back('{bits: c.bits << 1, len: c.len + 1});
                    codes.push_back('{bits: (c.bits << 1) | 10'b1, len: c.len + 1});
                end
            end
            foreach (codes[i])
            begin
                syms.push_back(SYM_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                load_code(syms[i], codes[i].bits, codes[i].len);
            end
            repeat ($urandom_range(10, 40))
            begin
                if ($urandom_range(0, 11) == 0)
                    send_noise();
                idx = $urandom_range(0, codes.size() - 1);
                decode_code(codes[idx].bits, codes[idx].len);
            end
        end

        // Drain: wait for every predicted result, then for any load still writing
        item_ch.valid <= 1'b0;
        steady = 1'b1;
        while (sb.decoded_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d tree loads and %0d decode steps over random code trees,",
                 sb.n_load, sb.n_decode);
        $display("giving %0d decoded symbols, %0d invalid codes, %0d too-long walks.",
                 sb.n_status[STATUS_OK], sb.n_status[STATUS_INVALID],
                 sb.n_status[STATUS_TOO_LONG]);
        if (sb.errors == 0 && sb.decoded_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end
endmodule
